/* hdl/bcra_pkg.sv */
// Shared codes and sizes for the BCD clock register adjust block.
`default_nettype none

package bcra_pkg;

   localparam int REG_DEPTH = 7;
   localparam logic [2:0] REG_LIMIT = 3'(REG_DEPTH);

   localparam logic [2:0] KIND_READ     = 3'd0;
   localparam logic [2:0] KIND_WRITE    = 3'd1;
   localparam logic [2:0] KIND_INCR     = 3'd2;
   localparam logic [2:0] KIND_TOG_AMPM = 3'd3;
   localparam logic [2:0] KIND_TOG_MODE = 3'd4;

   localparam logic [2:0] REG_SEC   = 3'd0;
   localparam logic [2:0] REG_MIN   = 3'd1;
   localparam logic [2:0] REG_HOUR  = 3'd2;
   localparam logic [2:0] REG_WDAY  = 3'd3;
   localparam logic [2:0] REG_DATE  = 3'd4;
   localparam logic [2:0] REG_MONTH = 3'd5;
   localparam logic [2:0] REG_YEAR  = 3'd6;

endpackage

`default_nettype wire

/* hdl/bcra_ram.sv */
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module bcra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 7
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/bcra_update.sv */
// Next-value logic for one register access: write, BCD increment and hour toggles.
`default_nettype none

module bcra_update (
   input  wire logic [2:0] kind,
   input  wire logic [2:0] reg_index,
   input  wire logic [7:0] write_data,
   input  wire logic [7:0] cur,
   output logic      [7:0] nxt
);

   function automatic logic [7:0] bcd_dec(input logic [7:0] b);
      bcd_dec = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
   endfunction

   // divide by ten through reciprocal 205/2048, exact for all 8-bit values
   function automatic logic [7:0] bcd_enc(input logic [7:0] n);
      logic [18:0] prod;
      logic [4:0]  q;
      logic [7:0]  qten;
      logic [7:0]  rem;
      prod = {11'b0, n} * 19'd205;
      q    = prod[15:11];
      qten = {q, 3'b000} + {2'b00, q, 1'b0};
      rem  = n - qten;
      bcd_enc = {q[3:0], rem[3:0]};
   endfunction

   function automatic logic [7:0] step_wrap(input logic [7:0] b, input logic [7:0] at,
                                            input logic [7:0] to);
      logic [7:0] d;
      d = bcd_dec(b) + 8'd1;
      if (d == at) begin
         d = to;
      end
      step_wrap = bcd_enc(d);
   endfunction

   function automatic logic [7:0] step_hours(input logic [7:0] r);
      logic [7:0] d;
      d = bcd_dec({3'b000, r[4:0]}) + 8'd1;
      if (d == 8'd13) begin
         d = 8'd1;
      end
      if (r[7:5] <= 3'd1) begin
         step_hours = step_wrap(r, 8'd24, 8'd0);
      end else if (r[7]) begin
         step_hours = r;
      end else begin
         step_hours = bcd_enc(d) | ((r[7:5] == 3'd2) ? 8'h40 : 8'h60);
      end
   endfunction

   function automatic logic [7:0] toggle_ampm(input logic [7:0] r);
      if (r[6:5] == 2'b11) begin
         toggle_ampm = r & 8'h5F;
      end else if (r[6]) begin
         toggle_ampm = r | 8'h60;
      end else begin
         toggle_ampm = r;
      end
   endfunction

   function automatic logic [7:0] toggle_mode(input logic [7:0] r);
      logic [7:0] d24;
      logic [7:0] d12;
      d24 = bcd_dec(r);
      d12 = bcd_dec({3'b000, r[4:0]}) + 8'd12;
      if (d12 == 8'd24) begin
         d12 = 8'd0;
      end
      if (!r[6]) begin
         if (d24 == 8'd0) begin
            toggle_mode = 8'h72;
         end else if (d24 > 8'd12) begin
            toggle_mode = bcd_enc(d24 - 8'd12) | 8'h60;
         end else begin
            toggle_mode = bcd_enc(d24) | 8'h40;
         end
      end else if (!r[5]) begin
         toggle_mode = r & 8'h1F;
      end else begin
         toggle_mode = bcd_enc(d12);
      end
   endfunction

   function automatic logic [7:0] incr_reg(input logic [2:0] idx, input logic [7:0] r);
      unique case (idx)
         bcra_pkg::REG_SEC,
         bcra_pkg::REG_MIN:   incr_reg = step_wrap(r, 8'd60, 8'd0);
         bcra_pkg::REG_HOUR:  incr_reg = step_hours(r);
         bcra_pkg::REG_WDAY:  incr_reg = step_wrap(r, 8'd8, 8'd1);
         bcra_pkg::REG_DATE:  incr_reg = step_wrap(r, 8'd32, 8'd1);
         bcra_pkg::REG_MONTH: incr_reg = step_wrap({1'b0, r[6:0]}, 8'd13, 8'd1);
         bcra_pkg::REG_YEAR:  incr_reg = step_wrap(r, 8'd100, 8'd0);
         default:             incr_reg = r;
      endcase
   endfunction

   always_comb begin
      unique case (kind)
         bcra_pkg::KIND_WRITE:    nxt = write_data;
         bcra_pkg::KIND_INCR:     nxt = incr_reg(reg_index, cur);
         bcra_pkg::KIND_TOG_AMPM: nxt = toggle_ampm(cur);
         bcra_pkg::KIND_TOG_MODE: nxt = toggle_mode(cur);
         default:                 nxt = cur;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/bcd_clock_register_adjust.sv */
// Top level: BCD time register file with read, write, increment and hour-mode toggles.
// Each transaction runs in two steps: the addressed entry is first read from the register
// RAM (registered read); then the new value is computed, written back and loaded into the
// result register. No new request is taken until the current one has finished, and the
// request side waits while the result register is full and not being taken. Toggle
// requests always work on the hours register. Reset clears all seven registers at once
// through per-entry valid bits; there is no clearing pass.
`default_nettype none

module bcd_clock_register_adjust (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [2:0] reg_index, [10:3] write_data, zero pad
   input  wire logic [2:0]  req_tuser,  // [2:0] kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata   // [7:0] read_data, [9:8] hour_format, zero pad
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic       state_ff, state_in;
   logic [2:0] kind_ff, kind_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] wd_ff, wd_in;
   logic [bcra_pkg::REG_DEPTH-1:0] vld_ff, vld_in;
   logic [1:0] hour_fmt_ff, hour_fmt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_fmt_ff, rsp_fmt_in;

   logic       req_fire;
   logic       issue;
   logic       idx_valid;
   logic [2:0] req_idx;
   logic [2:0] rd_addr;
   logic [2:0] wr_addr;
   logic       ram_we;
   logic [7:0] ram_q;
   logic [7:0] cur;
   logic [7:0] nxt;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign issue      = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign idx_valid  = idx_ff < bcra_pkg::REG_LIMIT;

   assign req_idx = (req_tuser[2:0] == bcra_pkg::KIND_TOG_AMPM ||
                     req_tuser[2:0] == bcra_pkg::KIND_TOG_MODE) ? bcra_pkg::REG_HOUR
                                                                : req_tdata[2:0];
   assign wr_addr = idx_valid ? idx_ff : bcra_pkg::REG_SEC;
   assign rd_addr = (state_ff == S_IDLE) ?
                    ((req_idx < bcra_pkg::REG_LIMIT) ? req_idx : bcra_pkg::REG_SEC) : wr_addr;
   assign ram_we  = issue && idx_valid;
   assign cur     = vld_ff[wr_addr] ? ram_q : 8'h00;

   bcra_ram #(
      .WIDTH (8),
      .DEPTH (bcra_pkg::REG_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_addr),
      .wr_data (nxt),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   bcra_update u_update (
      .kind       (kind_ff),
      .reg_index  (idx_ff),
      .write_data (wd_ff),
      .cur        (cur),
      .nxt        (nxt)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      idx_in       = idx_ff;
      wd_in        = wd_ff;
      vld_in       = vld_ff;
      hour_fmt_in  = hour_fmt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_fmt_in   = rsp_fmt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser[2:0];
               idx_in   = req_idx;
               wd_in    = req_tdata[10:3];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (issue) begin
               if (ram_we) begin
                  vld_in[wr_addr] = 1'b1;
                  if (idx_ff == bcra_pkg::REG_HOUR) begin
                     hour_fmt_in = nxt[6:5];
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = idx_valid ? nxt : 8'h00;
               rsp_fmt_in   = hour_fmt_in;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         hour_fmt_ff  <= 2'b00;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         hour_fmt_ff  <= hour_fmt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      idx_ff      <= idx_in;
      wd_ff       <= wd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fmt_ff  <= rsp_fmt_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_fmt_ff, rsp_data_ff};

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_EXEC)
      else $error("accepted transaction did not enter execute");

   a_issue_rsp: assert property (@(posedge clock) disable iff (reset)
      issue |=> rsp_tvalid)
      else $error("completed transaction produced no response");

   a_hour_fmt_clear: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[bcra_pkg::REG_HOUR] |-> hour_fmt_ff == 2'b00)
      else $error("hour format set while hours register never written");

   a_hour_fmt_track: assert property (@(posedge clock) disable iff (reset)
      (ram_we && idx_ff == bcra_pkg::REG_HOUR) |=> hour_fmt_ff == $past(nxt[6:5]))
      else $error("hour format shadow out of step with hours register");

endmodule

`default_nettype wire

/* dv/bcd_clock_register_adjust_test.sv */
// Self-checking testbench for the BCD clock register file: predicted readbacks vs the stream.
`default_nettype none

module bcd_clock_register_adjust_test;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] hour_format;
   } readback_type;

   class clock_regs_board;
      logic [7:0]   time_reg [bcra_pkg::REG_DEPTH];
      readback_type readback_q [$];
      int           mismatches;

      function new();
         foreach (time_reg[i]) time_reg[i] = 8'h00;
         mismatches = 0;
      endfunction

      function logic [7:0] decode(logic [7:0] b);
         return 8'(b[7:4] * 10 + b[3:0]);
      endfunction

      function logic [7:0] encode(logic [7:0] n);
         return 8'(((n / 10) << 4) | (n % 10));
      endfunction

      function logic [7:0] step_wrap(logic [7:0] b, logic [7:0] at, logic [7:0] to);
         logic [7:0] d;
         d = 8'(decode(b) + 1);
         if (d == at) d = to;
         return encode(d);
      endfunction

      function logic [7:0] step_hours(logic [7:0] r);
         logic [7:0] d;
         if (r[7:5] <= 3'd1) return step_wrap(r, 8'd24, 8'd0);
         if (r[7:5] > 3'd3) return r;
         d = 8'(decode({3'b000, r[4:0]}) + 1);
         if (d == 8'd13) d = 8'd1;
         return encode(d) | ((r[7:5] == 3'd2) ? 8'h40 : 8'h60);
      endfunction

      function logic [7:0] flip_ampm(logic [7:0] r);
         if (r[6:5] == 2'b11) return r & 8'h5F;
         if (r[6]) return r | 8'h60;
         return r;
      endfunction

      function logic [7:0] flip_mode(logic [7:0] r);
         logic [7:0] d;
         if (r[6:5] <= 2'd1) begin
            d = decode(r);
            if (d == 8'd0) return encode(8'd12) | 8'h60;
            if (d > 8'd12) return encode(d - 8'd12) | 8'h60;
            return encode(d) | 8'h40;
         end
         if (r[6:5] == 2'd2) return r & 8'h1F;
         d = 8'(decode({3'b000, r[4:0]}) + 12);
         if (d == 8'd24) d = 8'd0;
         return encode(d);
      endfunction

      function logic [7:0] bump(logic [2:0] idx, logic [7:0] r);
         case (idx)
            bcra_pkg::REG_SEC,
            bcra_pkg::REG_MIN:   return step_wrap(r, 8'd60, 8'd0);
            bcra_pkg::REG_HOUR:  return step_hours(r);
            bcra_pkg::REG_WDAY:  return step_wrap(r, 8'd8, 8'd1);
            bcra_pkg::REG_DATE:  return step_wrap(r, 8'd32, 8'd1);
            bcra_pkg::REG_MONTH: return step_wrap(r & 8'h7F, 8'd13, 8'd1);
            bcra_pkg::REG_YEAR:  return step_wrap(r, 8'd100, 8'd0);
            default:             return r;
         endcase
      endfunction

      function void apply_access(logic [2:0] kind, logic [2:0] idx, logic [7:0] wd);
         readback_type rb;
         rb.read_data = 8'h00;
         if (kind == bcra_pkg::KIND_TOG_AMPM || kind == bcra_pkg::KIND_TOG_MODE) begin
            time_reg[bcra_pkg::REG_HOUR] = (kind == bcra_pkg::KIND_TOG_AMPM) ?
                                           flip_ampm(time_reg[bcra_pkg::REG_HOUR]) :
                                           flip_mode(time_reg[bcra_pkg::REG_HOUR]);
            rb.read_data = time_reg[bcra_pkg::REG_HOUR];
         end else if (idx < bcra_pkg::REG_LIMIT) begin
            if (kind == bcra_pkg::KIND_WRITE) time_reg[idx] = wd;
            else if (kind == bcra_pkg::KIND_INCR) time_reg[idx] = bump(idx, time_reg[idx]);
            rb.read_data = time_reg[idx];
         end
         rb.hour_format = time_reg[bcra_pkg::REG_HOUR][6:5];
         readback_q.push_back(rb);
      endfunction

      function void compare_readback(logic [15:0] tdata);
         readback_type want;
         if (readback_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %h", $time, tdata);
            mismatches++;
            return;
         end
         want = readback_q.pop_front();
         if (tdata[7:0] !== want.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, want.read_data,
                     tdata[7:0]);
            mismatches++;
         end
         if (tdata[9:8] !== want.hour_format) begin
            $display("%0t: hour_format expected %h actual %h", $time, want.hour_format,
                     tdata[9:8]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = 16'h0000;
   logic [2:0]  req_tuser = bcra_pkg::KIND_READ;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   clock_regs_board board = new();
   int  cycle_count = 0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;
   bit  long_hold_req = 1'b0;
   int  hold_left = 0;

   bcd_clock_register_adjust uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.compare_readback(rsp_tdata);
   end

   // result-side backpressure
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = 89;
         rsp_tready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
         hold_left = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] bcd_pick(int lo, int hi);
      int n;
      n = ($urandom_range(0, 2) == 0) ? hi : $urandom_range(lo, hi);
      return 8'(((n / 10) << 4) | (n % 10));
   endfunction

   task automatic send_item(logic [2:0] kind, logic [2:0] idx, logic [7:0] wd);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 17);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, wd, idx};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      board.apply_access(kind, idx, wd);
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.readback_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] plausible_value(logic [2:0] idx);
      case (idx)
         bcra_pkg::REG_SEC,
         bcra_pkg::REG_MIN: return bcd_pick(0, 59);
         bcra_pkg::REG_HOUR: begin
            case ($urandom_range(0, 2))
               0:       return bcd_pick(0, 23);
               1:       return bcd_pick(1, 12) | 8'h40;
               default: return bcd_pick(1, 12) | 8'h60;
            endcase
         end
         bcra_pkg::REG_WDAY:  return bcd_pick(1, 7);
         bcra_pkg::REG_DATE:  return bcd_pick(1, 31);
         bcra_pkg::REG_MONTH: return bcd_pick(1, 12) | {$urandom_range(0, 1) == 1, 7'h00};
         default:             return bcd_pick(0, 99);
      endcase
   endfunction

   task automatic random_item();
      int         pick;
      logic [2:0] idx;
      logic [7:0] wd;
      pick = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 3) == 0) ? bcra_pkg::REG_HOUR : 3'($urandom_range(0, 6));
      wd   = 8'($urandom_range(0, 255));
      if (pick < 18) send_item(bcra_pkg::KIND_READ, idx, wd);
      else if (pick < 45)
         send_item(bcra_pkg::KIND_WRITE, idx,
                   ($urandom_range(0, 6) == 0) ? wd : plausible_value(idx));
      else if (pick < 82) send_item(bcra_pkg::KIND_INCR, idx, wd);
      else if (pick < 88)
         send_item(bcra_pkg::KIND_TOG_AMPM, 3'($urandom_range(0, 7)), wd);
      else if (pick < 94)
         send_item(bcra_pkg::KIND_TOG_MODE, 3'($urandom_range(0, 7)), wd);
      else send_item(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), wd);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: wraps, formats, spare kinds and the unused index
      send_item(bcra_pkg::KIND_READ, bcra_pkg::REG_SEC, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_SEC, 8'h59);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_SEC, 8'hFF);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_MIN, 8'h59);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_MIN, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_HOUR, 8'h23);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_HOUR, 8'h00);
      send_item(bcra_pkg::KIND_TOG_MODE, bcra_pkg::REG_YEAR, 8'h00);
      send_item(bcra_pkg::KIND_TOG_MODE, bcra_pkg::REG_HOUR, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_HOUR, 8'h72);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_HOUR, 8'h00);
      send_item(bcra_pkg::KIND_TOG_AMPM, bcra_pkg::REG_SEC, 8'h00);
      send_item(bcra_pkg::KIND_TOG_AMPM, bcra_pkg::REG_LIMIT, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_HOUR, 8'h15);
      send_item(bcra_pkg::KIND_TOG_MODE, bcra_pkg::REG_HOUR, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_HOUR, 8'h80);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_HOUR, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_WDAY, 8'h07);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_WDAY, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_DATE, 8'h31);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_DATE, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_MONTH, 8'h92);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_MONTH, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_YEAR, 8'hFF);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_YEAR, 8'h00);
      send_item(bcra_pkg::KIND_WRITE, bcra_pkg::REG_LIMIT, 8'hA5);
      send_item(bcra_pkg::KIND_INCR, bcra_pkg::REG_LIMIT, 8'h00);
      for (int k = int'(bcra_pkg::KIND_TOG_MODE) + 1; k < 8; k++)
         send_item(3'(k), bcra_pkg::REG_YEAR, 8'h5A);

      repeat (900) random_item();

      // long result stall while requests keep coming
      sender_idle_on = 1'b0;
      long_hold_req = 1'b1;
      repeat (40) random_item();
      sender_idle_on = 1'b1;

      drain();
      repeat (720) random_item();

      // tail with no idling on either side
      sender_idle_on = 1'b0;
      receiver_idle_on = 1'b0;
      repeat (200) random_item();

      drain();
      repeat (8) @(posedge clock);
      if (board.mismatches == 0 && board.readback_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
